// ===== rtl/core/knight_blocked_lattice_path_count_macros.svh =====
// Assertion macros used by the checker file of the path counter.
`ifndef KNIGHT_BLOCKED_LATTICE_PATH_COUNT_MACROS_SVH
`define KNIGHT_BLOCKED_LATTICE_PATH_COUNT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KLPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KLPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/klpc_pkg.sv =====
// Shared types, constants and helper functions of the knight-blocked path counter.
package klpc_pkg;

	localparam int GRID_SIZE = 32;
	localparam int COORD_W   = 5;
	localparam int COUNT_W   = 59;
	localparam int CNT_W     = COORD_W + 1;

	localparam logic [COORD_W-1:0] CoordMax = COORD_W'(GRID_SIZE - 1);

	// Token handed from cell to cell: the column that the cell just swept.
	typedef struct packed {
		logic               act;
		logic [COORD_W-1:0] col;
	} tok_t;

	// Knight position, broadcast to every cell.
	typedef struct packed {
		logic [COORD_W-1:0] kx;
		logic [COORD_W-1:0] ky;
	} knight_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	function automatic logic [COORD_W-1:0] clamp_coord(logic [COORD_W-1:0] v);
		return (v > CoordMax) ? CoordMax : v;
	endfunction

	function automatic logic is_blocked(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
	                                    logic [COORD_W-1:0] kx, logic [COORD_W-1:0] ky);
		logic [COORD_W-1:0] dx;
		logic [COORD_W-1:0] dy;
		dx = (x > kx) ? (x - kx) : (kx - x);
		dy = (y > ky) ? (y - ky) : (ky - y);
		return ((dx == COORD_W'(0)) && (dy == COORD_W'(0))) ||
		       ((dx == COORD_W'(1)) && (dy == COORD_W'(2))) ||
		       ((dx == COORD_W'(2)) && (dy == COORD_W'(1)));
	endfunction

endpackage

// ===== rtl/core/knight_blocked_lattice_path_count.sv =====
// Top level of the knight-blocked lattice path counter: sequencer plus a chain of row cells.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one query item: target corner
//   (target_x, target_y) and knight square (knight_x, knight_y). Output channel
//   (out_valid / out_stall) returns one item per query: path_count, the number of
//   monotone paths from the origin that avoid the knight and its attacked squares.
//   Target coordinates above GRID_SIZE-1 are clamped to the grid edge.
// Timing:
//   The row cells sweep the grid as a diagonal wavefront, one column per cycle per
//   cell. out_valid rises once the wavefront has passed the target square and the
//   result is loaded; the next item is taken only after that load, so one query
//   runs in the cell chain at a time. The wavefront length through the cell chain
//   sets how long a query runs.
// Reset:
//   arst_n clears the sequencer, the cell tokens and the output valid. Row counts
//   are cleared at the start of every query, not by reset.
// Backpressure:
//   The result sits in an output register and holds while out_stall is high; the
//   next query still runs, then waits in the sequencer with in_stall high.
module knight_blocked_lattice_path_count import klpc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [COORD_W-1:0] target_x,
	input  logic [COORD_W-1:0] target_y,
	input  logic [COORD_W-1:0] knight_x,
	input  logic [COORD_W-1:0] knight_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [COUNT_W-1:0] path_count
);

	// Chain wiring: entry i+1 is what cell i hands to cell i+1; entry 0 comes from the sequencer.
	tok_t                              tok_chain [GRID_SIZE+1];
	logic [GRID_SIZE-1:0][COUNT_W-1:0] row_cnt;
	logic                              clr;
	knight_t                           knight;

	klpc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.target_x   (target_x),
		.target_y   (target_y),
		.knight_x   (knight_x),
		.knight_y   (knight_y),
		.row_cnt    (row_cnt),
		.clr        (clr),
		.knight     (knight),
		.tok0       (tok_chain[0]),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.path_count (path_count)
	);

	// Cell i owns row_cnt[i]. Cell 0 has no lower neighbor, so it adds zero.
	for (genvar i = 0; i < GRID_SIZE; i++) begin : g_cell
		logic [COUNT_W-1:0] nb_cnt;

		if (i == 0) begin : g_first
			assign nb_cnt = '0;
		end else begin : g_rest
			assign nb_cnt = row_cnt[i-1];
		end

		klpc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.clr     (clr),
			.row_idx (COORD_W'(i)),
			.knight  (knight),
			.tok_in  (tok_chain[i]),
			.nb_cnt  (nb_cnt),
			.tok_out (tok_chain[i+1]),
			.cnt     (row_cnt[i])
		);
	end

endmodule

// ===== rtl/core/klpc_cell.sv =====
// One row cell: holds the path count of its y and updates it one column per token.
module klpc_cell import klpc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               clr,
	input  logic [COORD_W-1:0] row_idx,
	input  knight_t            knight,
	input  tok_t               tok_in,
	input  logic [COUNT_W-1:0] nb_cnt,
	output tok_t               tok_out,
	output logic [COUNT_W-1:0] cnt
);

	tok_t               tok_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [COUNT_W-1:0] cnt_nxt;
	logic               origin;

	assign origin = (tok_in.col == COORD_W'(0)) && (row_idx == COORD_W'(0));

	always_comb begin
		if (origin) begin
			cnt_nxt = COUNT_W'(1);
		end else if (is_blocked(tok_in.col, row_idx, knight.kx, knight.ky)) begin
			cnt_nxt = '0;
		end else begin
			cnt_nxt = cnt_q + nb_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (clr) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_in;
		end
	end

	always_ff @(posedge clk) begin
		if (clr) begin
			cnt_q <= '0;
		end else if (tok_in.act) begin
			cnt_q <= cnt_nxt;
		end
	end

	assign tok_out = tok_q;
	assign cnt     = cnt_q;

endmodule

// ===== rtl/core/klpc_ctrl.sv =====
// Query sequencer: latches a query, feeds column tokens to the chain, registers the result.
module klpc_ctrl import klpc_pkg::*; (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [COORD_W-1:0]                target_x,
	input  logic [COORD_W-1:0]                target_y,
	input  logic [COORD_W-1:0]                knight_x,
	input  logic [COORD_W-1:0]                knight_y,
	input  logic [GRID_SIZE-1:0][COUNT_W-1:0] row_cnt,
	output logic                              clr,
	output knight_t                           knight,
	output tok_t                              tok0,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [COUNT_W-1:0]                path_count
);

	state_t             state_q;
	state_t             state_nxt;
	logic [COORD_W-1:0] tx_q;
	logic [COORD_W-1:0] ty_q;
	knight_t            knight_q;
	logic [CNT_W-1:0]   col_q;
	logic [CNT_W-1:0]   cyc_q;
	logic [CNT_W-1:0]   last_cyc;
	logic               out_valid_q;
	logic [COUNT_W-1:0] path_count_q;
	logic               accept;
	logic               load;

	assign last_cyc = CNT_W'(tx_q) + CNT_W'(ty_q);

	always_comb begin
		state_nxt = state_q;
		in_stall  = 1'b1;
		accept    = 1'b0;
		load      = 1'b0;
		tok0      = '0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					accept    = 1'b1;
					state_nxt = ST_RUN;
				end
			end
			ST_RUN: begin
				tok0.act = (col_q <= CNT_W'(tx_q));
				tok0.col = col_q[COORD_W-1:0];
				if (cyc_q == last_cyc) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					load      = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			col_q       <= '0;
			cyc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				col_q <= '0;
				cyc_q <= '0;
			end else if (state_q == ST_RUN) begin
				if (tok0.act) begin
					col_q <= col_q + CNT_W'(1);
				end
				cyc_q <= cyc_q + CNT_W'(1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tx_q        <= clamp_coord(target_x);
			ty_q        <= clamp_coord(target_y);
			knight_q.kx <= knight_x;
			knight_q.ky <= knight_y;
		end
		if (load) begin
			path_count_q <= row_cnt[ty_q];
		end
	end

	assign clr        = accept;
	assign knight     = knight_q;
	assign out_valid  = out_valid_q;
	assign path_count = path_count_q;

endmodule

// ===== rtl/core/klpc_checker.sv =====
// Port-level checker of the path counter and its bind to the top level.
`include "knight_blocked_lattice_path_count_macros.svh"

module klpc_checker import klpc_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [COORD_W-1:0] target_x,
	input logic [COORD_W-1:0] target_y,
	input logic [COORD_W-1:0] knight_x,
	input logic [COORD_W-1:0] knight_y,
	input logic               out_valid,
	input logic               out_stall,
	input logic [COUNT_W-1:0] path_count
);

	// A held result keeps its value until taken.
	`KLPC_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(path_count), "stalled result changed")

	// One query at a time: the block is busy right after taking an item.
	`KLPC_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall, "input not stalled after accept")

	// A new result only appears at the end of a running query.
	`KLPC_ASSERT_IMP(a_result_from_work, clk, arst_n, $rose(out_valid), $past(in_stall), "result without a running query")

endmodule

bind knight_blocked_lattice_path_count klpc_checker u_klpc_checker (.*);

// ===== dv/tb_knight_blocked_lattice_path_count.sv =====
// Self-checking testbench for the knight-blocked lattice path counter.
module tb_knight_blocked_lattice_path_count import klpc_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	// Watchdog limit, in cycles with no item moving on either channel. The worst
	// legal quiet spell is the receiver hold-off below plus one full sweep.
	localparam int StallLimit   = 4000;
	// Hold-off length and the result count at which it starts.
	localparam int HoldOffLen   = 400;
	localparam int HoldOffAt    = 150;
	// Window of items / results in which neither side idles.
	localparam int QuietFrom    = 500;
	localparam int QuietTo      = 700;
	// Idle chance, percent per cycle.
	localparam int IdlePct      = 21;
	localparam int RandomQueries = 1180;
	// Drain time after the last result: longer than one full 32x32 sweep.
	localparam int DrainCycles  = 80;

	typedef struct packed {
		logic [COORD_W-1:0] tx;
		logic [COORD_W-1:0] ty;
		logic [COORD_W-1:0] kx;
		logic [COORD_W-1:0] ky;
	} query_t;

	typedef struct {
		query_t             q;
		logic [COUNT_W-1:0] count;
	} path_expect_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [COORD_W-1:0] target_x = '0;
	logic [COORD_W-1:0] target_y = '0;
	logic [COORD_W-1:0] knight_x = '0;
	logic [COORD_W-1:0] knight_y = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [COUNT_W-1:0] path_count;

	query_t       query_q[$];      // queries waiting to be offered
	path_expect_t path_expect_q[$]; // counts owed by the block, oldest first
	int           mismatches = 0;
	int           queries_sent = 0;
	int           counts_seen = 0;
	int           hold_left = 0;
	bit           hold_done = 1'b0;
	int           quiet_cycles = 0;

	knight_blocked_lattice_path_count u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.target_x  (target_x),
		.target_y  (target_y),
		.knight_x  (knight_x),
		.knight_y  (knight_y),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.path_count(path_count)
	);

	always #5 clk = ~clk;

	// Path count predictor: sweep x by columns, one running count per y.
	// Squares the knight sits on or attacks hold zero; the origin always holds one.
	function automatic logic [COUNT_W-1:0] count_paths(query_t q);
		logic [COUNT_W-1:0] column[GRID_SIZE];
		int tx, ty, kx, ky, dx, dy;
		bit hit;
		tx = (int'(q.tx) > GRID_SIZE - 1) ? GRID_SIZE - 1 : int'(q.tx);
		ty = (int'(q.ty) > GRID_SIZE - 1) ? GRID_SIZE - 1 : int'(q.ty);
		kx = int'(q.kx);
		ky = int'(q.ky);
		for (int y = 0; y < GRID_SIZE; y++)
			column[y] = '0;
		for (int x = 0; x <= tx; x++) begin
			for (int y = 0; y <= ty; y++) begin
				dx = (x > kx) ? x - kx : kx - x;
				dy = (y > ky) ? y - ky : ky - y;
				hit = (dx == 0 && dy == 0) || (dx == 1 && dy == 2) || (dx == 2 && dy == 1);
				if (x == 0 && y == 0)
					column[y] = COUNT_W'(1);
				else if (hit)
					column[y] = '0;
				else if (y > 0)
					column[y] = column[y] + column[y-1];
				// y == 0 keeps the previous column's value
			end
		end
		return column[ty];
	endfunction

	task automatic add_query(int tx, int ty, int kx, int ky);
		query_t q;
		q.tx = COORD_W'(tx);
		q.ty = COORD_W'(ty);
		q.kx = COORD_W'(kx);
		q.ky = COORD_W'(ky);
		query_q.push_back(q);
	endtask

	// Driver: offers the next query unless idling; a stalled query is held as is.
	always @(posedge clk or negedge arst_n) begin
		query_t       q;
		path_expect_t e;
		bit           idle;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				e.q.tx = target_x;
				e.q.ty = target_y;
				e.q.kx = knight_x;
				e.q.ky = knight_y;
				e.count = count_paths(e.q);
				path_expect_q.push_back(e);
				queries_sent++;
			end
			if (!(in_valid && in_stall)) begin
				idle = !(queries_sent >= QuietFrom && queries_sent < QuietTo) &&
				       ($urandom_range(99) < IdlePct);
				if (query_q.size() > 0 && !idle) begin
					q = query_q.pop_front();
					in_valid <= 1'b1;
					target_x <= q.tx;
					target_y <= q.ty;
					knight_x <= q.kx;
					knight_y <= q.ky;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted count against the oldest owed one, and
	// drives out_stall, including one long hold-off that backs the block up.
	always @(posedge clk or negedge arst_n) begin
		path_expect_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				counts_seen++;
				if (path_expect_q.size() == 0) begin
					mismatches++;
					$display("%0t: path_count expected none, got %0d", $time, path_count);
				end else begin
					e = path_expect_q.pop_front();
					if (path_count !== e.count) begin
						mismatches++;
						$display("%0t: path_count expected %0d, got %0d (target %0d,%0d knight %0d,%0d)",
						         $time, e.count, path_count, e.q.tx, e.q.ty, e.q.kx, e.q.ky);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!hold_done && counts_seen >= HoldOffAt) begin
				hold_done = 1'b1;
				hold_left = HoldOffLen;
				out_stall <= 1'b1;
			end else if (counts_seen >= QuietFrom && counts_seen < QuietTo) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < IdlePct);
			end
		end
	end

	// Watchdog: too long with no item moving on either channel ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= StallLimit) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int tx, ty, kx, ky;

		// Directed corners and special cases.
		add_query(0, 0, 0, 0);      // knight on origin, target is origin: still one
		add_query(0, 0, 31, 31);
		add_query(1, 2, 0, 0);      // target attacked by knight on origin
		add_query(2, 1, 0, 0);
		add_query(31, 31, 0, 0);    // knight on origin, full grid
		add_query(31, 31, 31, 31);  // knight on target
		add_query(31, 31, 29, 30);  // target attacked
		add_query(31, 31, 30, 29);
		add_query(31, 31, 31, 0);
		add_query(31, 31, 0, 31);
		add_query(31, 31, 16, 15);
		add_query(31, 31, 30, 31);
		add_query(31, 0, 15, 0);    // single row cut by the knight
		add_query(31, 0, 31, 1);
		add_query(0, 31, 0, 16);    // single column cut
		add_query(0, 31, 1, 0);     // attacked square on the only column
		add_query(5, 5, 20, 20);    // knight far from the rectangle
		add_query(10, 21, 21, 10);
		add_query(21, 10, 10, 21);
		add_query(31, 31, 2, 1);
		add_query(1, 1, 0, 2);
		add_query(31, 31, 31, 30);

		// Random queries: mostly small rectangles with the knight in or near them.
		for (int i = 0; i < RandomQueries; i++) begin
			if ($urandom_range(99) < 50) begin
				tx = $urandom_range(7);
				ty = $urandom_range(7);
			end else begin
				tx = $urandom_range(31);
				ty = $urandom_range(31);
			end
			if ($urandom_range(99) < 65) begin
				kx = $urandom_range((tx + 2 > 31) ? 31 : tx + 2);
				ky = $urandom_range((ty + 2 > 31) ? 31 : ty + 2);
			end else begin
				kx = $urandom_range(31);
				ky = $urandom_range(31);
			end
			add_query(tx, ty, kx, ky);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Poll on the falling edge, away from the driver and monitor updates.
		do
			@(negedge clk);
		while (query_q.size() > 0 || in_valid || path_expect_q.size() > 0);
		repeat (DrainCycles) @(negedge clk);

		if (mismatches == 0 && path_expect_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
